@@ src/days_until_date_top_assert.svh @@
// Assertion macros for the days_until_date top level.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef DAYS_UNTIL_DATE_TOP_ASSERT_SVH
`define DAYS_UNTIL_DATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DUD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("days_until_date: assertion failed");
`define DUD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("days_until_date: assertion failed");
`else
`define DUD_ASSERT_SAME(lbl, ante, cons)
`define DUD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/dud_pkg.sv @@
// Shared types, constants and calendar tables for the day counter.
// No dependencies.
package dud_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DAYS_W  = 22;

	localparam logic [YEAR_W+1:0] MAX_YEAR = 14'd4095;
	localparam int DAYS_PER_YEAR = 365;

	// floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for 12-bit years
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_100   = (1 << RECIP_SHIFT) / 100 + 1;
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam int CENT_W      = PROD_W - RECIP_SHIFT;
	localparam int QUAD_W      = CENT_W - 2;

	typedef struct packed {
		logic [YEAR_W-1:0]  due_year;
		logic [MONTH_W-1:0] due_month;
		logic [DAY_W-1:0]   due_day;
		logic               final_item;
	} due_item_t;

	typedef struct packed {
		logic signed [DAYS_W-1:0] days_left;
		logic                     date_ok;
		logic                     final_result;
	} result_item_t;

	typedef struct packed {
		logic load_prod;
		logic load_frac;
	} year_ctrl_t;

	typedef struct packed {
		logic [CENT_W-1:0] c100;
		logic [QUAD_W-1:0] c400;
		logic              leap;
	} year_info_t;

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mi);
		logic [8:0] n;
		case (mi)
			4'd0:    n = 9'd0;
			4'd1:    n = 9'd31;
			4'd2:    n = 9'd59;
			4'd3:    n = 9'd90;
			4'd4:    n = 9'd120;
			4'd5:    n = 9'd151;
			4'd6:    n = 9'd181;
			4'd7:    n = 9'd212;
			4'd8:    n = 9'd243;
			4'd9:    n = 9'd273;
			4'd10:   n = 9'd304;
			4'd11:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	// month 0 counts as January, above 12 as December
	function automatic logic [MONTH_W-1:0] month_index(input logic [MONTH_W-1:0] m);
		logic [MONTH_W-1:0] mi;
		if (m == '0)
			mi = '0;
		else if (m > 4'd12)
			mi = 4'd11;
		else
			mi = m - 4'd1;
		return mi;
	endfunction

endpackage

@@ src/dud_if.sv @@
// Valid/ready channels for deadline words in and day-count words out.
// Depends on dud_pkg for the payload types.
interface dud_req_if import dud_pkg::*; ();
	logic      valid;
	logic      ready;
	due_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dud_rsp_if import dud_pkg::*; ();
	logic         valid;
	logic         ready;
	result_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/dud_year_unit.sv @@
// Century and leap figures for one year: ceil(y/100), ceil(y/400), leap flag.
// Two steps: reciprocal multiply, then remainder check. Depends on dud_pkg.
module dud_year_unit import dud_pkg::*; (
	input  logic              clk,
	input  year_ctrl_t        ctrl,
	input  logic [YEAR_W-1:0] year,
	output year_info_t        info
);

	logic [PROD_W-1:0] prod_q;
	logic [CENT_W-1:0] f100;
	logic [YEAR_W-1:0] hundreds;
	logic              rem_zero;
	logic [CENT_W-1:0] c100;
	logic [CENT_W-1:0] c400_sum;
	year_info_t        info_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_prod)
			prod_q <= PROD_W'(year) * PROD_W'(RECIP_100);
	end

	assign f100     = prod_q[PROD_W-1:RECIP_SHIFT];
	assign hundreds = YEAR_W'(f100) * YEAR_W'(100);
	assign rem_zero = (year == hundreds);
	assign c100     = f100 + CENT_W'(!rem_zero);
	// ceil(y/400) = ceil(ceil(y/100)/4)
	assign c400_sum = c100 + CENT_W'(3);

	always_ff @(posedge clk) begin
		if (ctrl.load_frac) begin
			info_q.c100 <= c100;
			info_q.c400 <= c400_sum[CENT_W-1:2];
			info_q.leap <= (year[1:0] == 2'b00) && (!rem_zero || (f100[1:0] == 2'b00));
		end
	end

	assign info = info_q;

endmodule

@@ src/days_until_date_top.sv @@
// Signed Gregorian day count from the programmed current date to a deadline.
// Takes a new deadline word only when idle, once the last result word is loaded into the output register.
// The sequencer runs eight steps per date (today, then the deadline) through one
// shared add/subtract accumulator and one reciprocal multiplier for the centuries.
// Reset (arst_n low, asynchronous): idle, no result pending, today = 2024-01-01.
// Depends on dud_pkg, dud_if, dud_year_unit and days_until_date_top_assert.svh.
`include "days_until_date_top_assert.svh"
module days_until_date_top import dud_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [YEAR_W-1:0] cfg_wdata,
	dud_req_if.sink           req,
	dud_rsp_if.source         rsp
);

	localparam logic [1:0] REG_TODAY_YEAR  = 2'd0;
	localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
	localparam logic [1:0] REG_TODAY_DAY   = 2'd2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_FRAC = 4'd2;
	localparam logic [3:0] ST_YR   = 4'd3;
	localparam logic [3:0] ST_Q4   = 4'd4;
	localparam logic [3:0] ST_C100 = 4'd5;
	localparam logic [3:0] ST_C400 = 4'd6;
	localparam logic [3:0] ST_MON  = 4'd7;
	localparam logic [3:0] ST_DAY  = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [YEAR_W-1:0]  today_year_q;
	logic [MONTH_W-1:0] today_month_q;
	logic [DAY_W-1:0]   today_day_q;

	logic [3:0]         state_q;
	logic               sel_q;
	due_item_t          due_q;
	logic signed [DAYS_W-1:0] acc_q;
	logic               rsp_valid_q;
	result_item_t       rsp_data_q;

	logic [YEAR_W-1:0]  cur_year;
	logic [MONTH_W-1:0] cur_month;
	logic [DAY_W-1:0]   cur_day;
	logic [MONTH_W-1:0] mi;
	logic [YEAR_W:0]    q4_sum;
	logic signed [DAYS_W-1:0] op;
	logic signed [DAYS_W-1:0] acc_next;
	logic               sub;
	logic               accept;
	logic               load_rsp;
	logic               date_ok;
	year_ctrl_t         yctrl;
	year_info_t         yinfo;

	assign accept   = req.valid && req.ready;
	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign cur_year  = sel_q ? due_q.due_year  : today_year_q;
	assign cur_month = sel_q ? due_q.due_month : today_month_q;
	assign cur_day   = sel_q ? due_q.due_day   : today_day_q;
	assign mi        = month_index(cur_month);
	assign q4_sum    = {1'b0, cur_year} + (YEAR_W+1)'(3);

	assign yctrl.load_prod = (state_q == ST_DIV);
	assign yctrl.load_frac = (state_q == ST_FRAC);

	dud_year_unit u_year (
		.clk  (clk),
		.ctrl (yctrl),
		.year (cur_year),
		.info (yinfo)
	);

	// one term of the serial day number per step
	always_comb begin
		case (state_q)
			ST_YR:   op = DAYS_W'(cur_year) * DAYS_W'(DAYS_PER_YEAR);
			ST_Q4:   op = DAYS_W'(q4_sum[YEAR_W:2]);
			ST_C100: op = DAYS_W'(yinfo.c100);
			ST_C400: op = DAYS_W'(yinfo.c400);
			ST_MON:  op = DAYS_W'(days_before(mi)) + DAYS_W'((mi >= 4'd2) && yinfo.leap);
			ST_DAY:  op = DAYS_W'(cur_day);
			default: op = '0;
		endcase
	end

	// today's terms are subtracted; the century term flips sign
	assign sub      = (state_q == ST_C100) ^ !sel_q;
	assign acc_next = sub ? acc_q - op : acc_q + op;

	assign date_ok = ({2'b00, due_q.due_year} <= MAX_YEAR)
		&& (due_q.due_month != '0) && (due_q.due_month <= 4'd12)
		&& (due_q.due_day != '0)
		&& (due_q.due_day <= month_len(due_q.due_month, yinfo.leap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_year_q  <= 12'd2024;
			today_month_q <= 4'd1;
			today_day_q   <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TODAY_YEAR:  today_year_q  <= cfg_wdata;
				REG_TODAY_MONTH: today_month_q <= cfg_wdata[MONTH_W-1:0];
				REG_TODAY_DAY:   today_day_q   <= cfg_wdata[DAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						sel_q   <= 1'b0;
					end
				end
				ST_DIV:  state_q <= ST_FRAC;
				ST_FRAC: state_q <= ST_YR;
				ST_YR:   state_q <= ST_Q4;
				ST_Q4:   state_q <= ST_C100;
				ST_C100: state_q <= ST_C400;
				ST_C400: state_q <= ST_MON;
				ST_MON:  state_q <= ST_DAY;
				ST_DAY: begin
					if (sel_q) begin
						state_q <= ST_DONE;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DONE: begin
					if (load_rsp)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			due_q <= req.data;
			acc_q <= '0;
		end else if (state_q >= ST_YR && state_q <= ST_DAY) begin
			acc_q <= acc_next;
		end
	end

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load_rsp)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_data_q.days_left    <= date_ok ? acc_q : '0;
			rsp_data_q.date_ok      <= date_ok;
			rsp_data_q.final_result <= due_q.final_item;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	`DUD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	`DUD_ASSERT_SAME(a_bad_date_zero, rsp.valid && !rsp.data.date_ok, rsp.data.days_left == '0)
	`DUD_ASSERT_NEXT(a_load_from_done, !rsp.valid, !rsp.valid || $past(state_q == ST_DONE))

endmodule
